// File: rtl/dac_pkg.sv
// Shared types and constants for the driver alert classifier.
// Holds the input and result payload structs, register indexes and result codes.
// No dependencies.
`timescale 1ns / 1ps

package dac_pkg;

	// Input sample and result payloads; first member sits at the MSB.
	typedef struct packed {
		logic        [11:0] drowsy_raw;
		logic        [11:0] attention_raw;
		logic signed [15:0] tilt_x;
		logic signed [15:0] tilt_y;
		logic               tilt_valid;
		logic        [31:0] now_ms;
	} dac_in_t;

	typedef struct packed {
		logic [2:0]  severity;
		logic [1:0]  event_kind;
		logic [11:0] confidence;
		logic        head_down;
		logic [1:0]  led_colour;
		logic        buzzer_on;
		logic        report;
	} dac_out_t;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_DROWSY_HIGH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DROWSY_LOW    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ATTENTION_LOW = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ATTENTION_MID = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TILT_LIMIT    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BEEP_MS       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_MS   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SEND_INTERVAL = 3'd7;

	// Register reset values.
	localparam logic [11:0] RST_DROWSY_HIGH   = 12'd2866;
	localparam logic [11:0] RST_DROWSY_LOW    = 12'd1638;
	localparam logic [12:0] RST_ATTENTION_LOW = 13'd1229;
	localparam logic [12:0] RST_ATTENTION_MID = 13'd2457;
	localparam logic [15:0] RST_TILT_LIMIT    = 16'd6553;
	localparam logic [15:0] RST_BEEP_MS       = 16'd500;
	localparam logic [15:0] RST_COOLDOWN_MS   = 16'd2000;
	localparam logic [15:0] RST_SEND_INTERVAL = 16'd5000;

	// Event kinds and LED colours.
	localparam logic [1:0] KIND_NORMAL    = 2'd0;
	localparam logic [1:0] KIND_DROWSY    = 2'd1;
	localparam logic [1:0] KIND_ATTENTION = 2'd2;

	localparam logic [1:0] LED_GREEN  = 2'd0;
	localparam logic [1:0] LED_YELLOW = 2'd1;
	localparam logic [1:0] LED_RED    = 2'd2;

	localparam logic [2:0] SEV_MIN = 3'd1;
	localparam logic [2:0] SEV_MAX = 3'd5;

	localparam logic [11:0] FULL_SCALE = 12'd4095;

	// x / 5 as (x * 52429) >> 18, exact for x below 2^18.
	localparam logic [15:0] CONF_RECIP = 16'd52429;
	localparam int unsigned CONF_SHIFT = 18;

endpackage

// File: rtl/driver_alert_classifier.sv
// Driver alert classifier: one sample in, one scored result out.
// Each transferred sample passes through stage one and then the result register to the output.
// Throughput: one sample per cycle; input stalls only while stage one holds a
// sample and the result register is full and stalled.
// Reset clears beep and report history and loads the register defaults.
// Depends on dac_pkg.
`timescale 1ns / 1ps

module driver_alert_classifier (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [dac_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dac_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  dac_pkg::dac_in_t                  in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output dac_pkg::dac_out_t                 out_data
);
	import dac_pkg::*;

	// Configuration registers
	logic [11:0] drowsy_high_q, drowsy_low_q;
	logic [12:0] attention_low_q, attention_mid_q;
	logic [15:0] tilt_limit_q, beep_ms_q, cooldown_ms_q, send_interval_q;

	// History
	logic [31:0] beep_start_q, beep_end_q, last_report_q;
	logic [2:0]  reported_sev_q;
	logic [1:0]  reported_kind_q;
	logic        ever_reported_q;

	// Pipeline
	logic        valid_s1;
	dac_in_t     data_s1;
	logic        out_valid_q;
	dac_out_t    out_q;
	logic        advance;
	logic        load_s1;

	// Per-sample logic
	logic [16:0] mag_x, mag_y;
	logic        head;
	logic [2:0]  score;
	logic [2:0]  sev;
	logic [1:0]  kind;
	logic [1:0]  led;
	logic [12:0] conf_base;
	logic [14:0] conf_num;
	logic [30:0] conf_prod;
	logic        beep_start;
	logic [31:0] beep_end_next;
	logic        buzz;
	logic        rep;
	dac_out_t    result;

	assign advance   = !out_valid_q || !out_stall;
	// Stage one takes a new sample when it is empty or its sample moves on
	assign load_s1   = advance || !valid_s1;
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		mag_x = data_s1.tilt_x[15] ? (17'h10000 - {1'b0, data_s1.tilt_x})
			: {1'b0, data_s1.tilt_x};
		mag_y = data_s1.tilt_y[15] ? (17'h10000 - {1'b0, data_s1.tilt_y})
			: {1'b0, data_s1.tilt_y};
		head = data_s1.tilt_valid &&
			((mag_x > {1'b0, tilt_limit_q}) || (mag_y > {1'b0, tilt_limit_q}));

		score = 3'd0;
		if (data_s1.drowsy_raw > drowsy_high_q) begin
			score = score + 3'd2;
		end else if (data_s1.drowsy_raw > drowsy_low_q) begin
			score = score + 3'd1;
		end
		if ({1'b0, data_s1.attention_raw} < attention_low_q) begin
			score = score + 3'd2;
		end else if ({1'b0, data_s1.attention_raw} < attention_mid_q) begin
			score = score + 3'd1;
		end
		if (head) begin
			score = score + 3'd2;
		end

		if (score <= SEV_MIN) begin
			sev = SEV_MIN;
		end else if (score >= SEV_MAX) begin
			sev = SEV_MAX;
		end else begin
			sev = score;
		end

		// (d + 4095 - a) never goes negative, so 13 bits hold it
		conf_base = {1'b0, data_s1.drowsy_raw} + {1'b0, FULL_SCALE}
			- {1'b0, data_s1.attention_raw};
		conf_num  = {1'b0, conf_base, 1'b0} + (head ? {3'b0, FULL_SCALE} : 15'd0);
		conf_prod = 31'(conf_num) * 31'(CONF_RECIP);

		if (sev <= 3'd2) begin
			led = LED_GREEN;
		end else if (sev <= 3'd4) begin
			led = LED_YELLOW;
		end else begin
			led = LED_RED;
		end

		if (sev <= 3'd2) begin
			kind = KIND_NORMAL;
		end else if (({1'b0, data_s1.drowsy_raw} + {1'b0, data_s1.attention_raw})
				>= {1'b0, FULL_SCALE}) begin
			kind = KIND_DROWSY;
		end else begin
			kind = KIND_ATTENTION;
		end

		beep_start = (sev == SEV_MAX) && (data_s1.now_ms > beep_end_q) &&
			((data_s1.now_ms - beep_start_q) >= {16'd0, cooldown_ms_q});
		beep_end_next = beep_start ? (data_s1.now_ms + {16'd0, beep_ms_q}) : beep_end_q;
		buzz = (sev == SEV_MAX) && (data_s1.now_ms <= beep_end_next);

		rep = (!ever_reported_q || (kind != reported_kind_q) || (sev != reported_sev_q)) &&
			((data_s1.now_ms - last_report_q) >= {16'd0, send_interval_q});

		result.severity   = sev;
		result.event_kind = kind;
		result.confidence = conf_prod[CONF_SHIFT +: 12];
		result.head_down  = head;
		result.led_colour = led;
		result.buzzer_on  = buzz;
		result.report     = rep;
	end

	// Control, configuration and history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1        <= 1'b0;
			out_valid_q     <= 1'b0;
			drowsy_high_q   <= RST_DROWSY_HIGH;
			drowsy_low_q    <= RST_DROWSY_LOW;
			attention_low_q <= RST_ATTENTION_LOW;
			attention_mid_q <= RST_ATTENTION_MID;
			tilt_limit_q    <= RST_TILT_LIMIT;
			beep_ms_q       <= RST_BEEP_MS;
			cooldown_ms_q   <= RST_COOLDOWN_MS;
			send_interval_q <= RST_SEND_INTERVAL;
			beep_start_q    <= 32'd0;
			beep_end_q      <= 32'd0;
			last_report_q   <= 32'd0;
			reported_sev_q  <= 3'd0;
			reported_kind_q <= 2'd0;
			ever_reported_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DROWSY_HIGH:   drowsy_high_q   <= cfg_data[11:0];
					REG_DROWSY_LOW:    drowsy_low_q    <= cfg_data[11:0];
					REG_ATTENTION_LOW: attention_low_q <= cfg_data[12:0];
					REG_ATTENTION_MID: attention_mid_q <= cfg_data[12:0];
					REG_TILT_LIMIT:    tilt_limit_q    <= cfg_data;
					REG_BEEP_MS:       beep_ms_q       <= cfg_data;
					REG_COOLDOWN_MS:   cooldown_ms_q   <= cfg_data;
					REG_SEND_INTERVAL: send_interval_q <= cfg_data;
					default: ;
				endcase
			end

			if (load_s1) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end

			// Commit history only when the sample leaves stage one
			if (advance && valid_s1) begin
				if (beep_start) begin
					beep_start_q <= data_s1.now_ms;
					beep_end_q   <= beep_end_next;
				end
				if (rep) begin
					last_report_q   <= data_s1.now_ms;
					reported_sev_q  <= sev;
					reported_kind_q <= kind;
					ever_reported_q <= 1'b1;
				end
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (load_s1) begin
			data_s1 <= in_data;
		end
		if (advance && valid_s1) begin
			out_q <= result;
		end
	end

endmodule

// File: tb/tb.sv
// Self-checking bench for driver_alert_classifier: drives sensor samples and
// register writes, predicts each scored result in-bench and checks it on arrival.
// Depends on dac_pkg and the driver_alert_classifier RTL.
`timescale 1ns / 1ps

module tb;
	import dac_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	dac_in_t               in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	dac_out_t              out_data;

	// Predicted copy of the register file.
	logic [11:0] lim_drowsy_hi = RST_DROWSY_HIGH;
	logic [11:0] lim_drowsy_lo = RST_DROWSY_LOW;
	logic [12:0] lim_att_lo    = RST_ATTENTION_LOW;
	logic [12:0] lim_att_mid   = RST_ATTENTION_MID;
	logic [15:0] lim_tilt      = RST_TILT_LIMIT;
	logic [15:0] beep_len      = RST_BEEP_MS;
	logic [15:0] beep_gap      = RST_COOLDOWN_MS;
	logic [15:0] send_gap      = RST_SEND_INTERVAL;

	// Predicted beeper and report history.
	logic [31:0] beep_from_ms  = '0;
	logic [31:0] beep_until_ms = '0;
	logic [31:0] last_sent_ms  = '0;
	logic [2:0]  sent_sev      = '0;
	logic [1:0]  sent_kind     = '0;
	logic        sent_any      = 1'b0;

	dac_out_t    pending_alerts[$];
	int          mismatch_count = 0;
	int          cycle_count = 0;
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	int          hold_cycles = 0;
	logic [31:0] sim_ms = '0;

	driver_alert_classifier u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results pending", cycle_count,
				pending_alerts.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic dac_out_t classify_sample(input dac_in_t s);
		dac_out_t    r;
		int          mag_x;
		int          mag_y;
		int unsigned pts;
		int unsigned d;
		int unsigned a;
		int unsigned conf;
		logic        head;
		logic [31:0] since;
		d = s.drowsy_raw;
		a = s.attention_raw;
		mag_x = $signed(s.tilt_x);
		mag_y = $signed(s.tilt_y);
		if (mag_x < 0) mag_x = -mag_x;
		if (mag_y < 0) mag_y = -mag_y;
		head = s.tilt_valid && (mag_x > int'(lim_tilt) || mag_y > int'(lim_tilt));

		pts = 0;
		if (s.drowsy_raw > lim_drowsy_hi) pts += 2;
		else if (s.drowsy_raw > lim_drowsy_lo) pts += 1;
		if ({1'b0, s.attention_raw} < lim_att_lo) pts += 2;
		else if ({1'b0, s.attention_raw} < lim_att_mid) pts += 1;
		if (head) pts += 2;

		r = '0;
		if (pts <= 1) r.severity = SEV_MIN;
		else if (pts >= 5) r.severity = SEV_MAX;
		else r.severity = 3'(pts);

		conf = ((d + 4095 - a) * 2 + (head ? 4095 : 0)) / 5;
		r.confidence = 12'(conf);
		r.head_down = head;

		if (r.severity <= 3'd2) r.led_colour = LED_GREEN;
		else if (r.severity <= 3'd4) r.led_colour = LED_YELLOW;
		else r.led_colour = LED_RED;

		if (r.severity == SEV_MAX) begin
			since = s.now_ms - beep_from_ms;
			if (s.now_ms > beep_until_ms && since >= {16'd0, beep_gap}) begin
				beep_from_ms = s.now_ms;
				beep_until_ms = s.now_ms + {16'd0, beep_len};
			end
			r.buzzer_on = (s.now_ms <= beep_until_ms);
		end

		if (r.severity <= 3'd2) r.event_kind = KIND_NORMAL;
		else if (d + a >= 4095) r.event_kind = KIND_DROWSY;
		else r.event_kind = KIND_ATTENTION;

		since = s.now_ms - last_sent_ms;
		if ((!sent_any || r.event_kind != sent_kind || r.severity != sent_sev) &&
			since >= {16'd0, send_gap}) begin
			last_sent_ms = s.now_ms;
			sent_sev = r.severity;
			sent_kind = r.event_kind;
			sent_any = 1'b1;
			r.report = 1'b1;
		end
		return r;
	endfunction

	function automatic dac_in_t sample_of(input int d, input int a, input int x, input int y,
		input logic v, input logic [31:0] t);
		dac_in_t s;
		s.drowsy_raw = 12'(d);
		s.attention_raw = 12'(a);
		s.tilt_x = 16'(x);
		s.tilt_y = 16'(y);
		s.tilt_valid = v;
		s.now_ms = t;
		return s;
	endfunction

	// Mostly a running clock with alarming bursts; now and then a time jump or wrap.
	function automatic dac_in_t random_sample();
		dac_in_t     s;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 45) begin
			s.drowsy_raw = 12'($urandom_range(4095, 2500));
			s.attention_raw = 12'($urandom_range(1600, 0));
		end else begin
			s.drowsy_raw = 12'($urandom);
			s.attention_raw = 12'($urandom);
		end
		if ($urandom_range(1) == 0) begin
			s.tilt_x = 16'($urandom);
			s.tilt_y = 16'($urandom);
		end else begin
			s.tilt_x = 16'(int'($urandom_range(16000)) - 8000);
			s.tilt_y = 16'(int'($urandom_range(16000)) - 8000);
		end
		s.tilt_valid = ($urandom_range(9) != 0);
		pick = $urandom_range(99);
		if (pick < 6) sim_ms = $urandom;
		else if (pick < 8) sim_ms = 32'hFFFF_FFFF - $urandom_range(3000);
		else sim_ms = sim_ms + $urandom_range(1200);
		s.now_ms = sim_ms;
		return s;
	endfunction

	// Receiver: a requested hold-off wins over the random stall.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_stall <= (int'($urandom_range(99)) < stall_pct);
		end
	end

	always @(posedge clk) begin
		dac_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_alerts.size() == 0) begin
				if (mismatch_count < 10)
					$display("%0t: result %h with no sample pending", $realtime, out_data);
				mismatch_count <= mismatch_count + 1;
			end else begin
				want = pending_alerts.pop_front();
				if (out_data.severity !== want.severity ||
					out_data.event_kind !== want.event_kind ||
					out_data.confidence !== want.confidence ||
					out_data.head_down !== want.head_down ||
					out_data.led_colour !== want.led_colour ||
					out_data.buzzer_on !== want.buzzer_on ||
					out_data.report !== want.report) begin
					if (mismatch_count < 10) begin
						$display("%0t: mismatch sev %0d/%0d kind %0d/%0d conf %0d/%0d",
							$realtime, want.severity, out_data.severity, want.event_kind,
							out_data.event_kind, want.confidence, out_data.confidence);
						$display("    head %0d/%0d led %0d/%0d buzz %0d/%0d report %0d/%0d",
							want.head_down, out_data.head_down, want.led_colour,
							out_data.led_colour, want.buzzer_on, out_data.buzzer_on,
							want.report, out_data.report);
					end
					mismatch_count <= mismatch_count + 1;
				end
			end
		end
	end

	// Called and returns at a falling edge; predicts at the transfer edge.
	task automatic send_sample(input dac_in_t s);
		while (int'($urandom_range(99)) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_alerts.push_back(classify_sample(s));
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_alerts.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_DROWSY_HIGH:   lim_drowsy_hi = value[11:0];
			REG_DROWSY_LOW:    lim_drowsy_lo = value[11:0];
			REG_ATTENTION_LOW: lim_att_lo = value[12:0];
			REG_ATTENTION_MID: lim_att_mid = value[12:0];
			REG_TILT_LIMIT:    lim_tilt = value;
			REG_BEEP_MS:       beep_len = value;
			REG_COOLDOWN_MS:   beep_gap = value;
			REG_SEND_INTERVAL: send_gap = value;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic program_regs(input logic [15:0] dh, input logic [15:0] dl,
		input logic [15:0] al, input logic [15:0] am, input logic [15:0] tilt,
		input logic [15:0] beep, input logic [15:0] cool, input logic [15:0] send);
		wait_idle();
		write_reg(REG_DROWSY_HIGH, dh);
		write_reg(REG_DROWSY_LOW, dl);
		write_reg(REG_ATTENTION_LOW, al);
		write_reg(REG_ATTENTION_MID, am);
		write_reg(REG_TILT_LIMIT, tilt);
		write_reg(REG_BEEP_MS, beep);
		write_reg(REG_COOLDOWN_MS, cool);
		write_reg(REG_SEND_INTERVAL, send);
	endtask

	task automatic set_pace(input int idle, input int stall);
		send_idle_pct = idle;
		stall_pct = stall;
	endtask

	task automatic run_random(input int count);
		repeat (count) send_sample(random_sample());
	endtask

	// Reset thresholds: boundaries, kinds, beeper cooldown, report interval, wrap.
	task automatic test_directed_cases();
		set_pace(0, 0);
		send_sample(sample_of(0, 0, 0, 0, 1'b0, 32'd0));
		send_sample(sample_of(4095, 4095, 32767, 0, 1'b1, 32'd1));
		send_sample(sample_of(0, 4095, -32768, -32768, 1'b0, 32'd2));
		send_sample(sample_of(4095, 0, -32768, 0, 1'b1, 32'd100));
		send_sample(sample_of(4095, 0, 0, 6554, 1'b1, 32'd3000));
		send_sample(sample_of(4095, 0, 6554, 0, 1'b1, 32'd3500));
		send_sample(sample_of(4095, 0, 6553, -6553, 1'b1, 32'd3501));
		send_sample(sample_of(4095, 0, -6554, 0, 1'b1, 32'd3502));
		send_sample(sample_of(4095, 0, -6554, 0, 1'b1, 32'd5000));
		send_sample(sample_of(3000, 2000, 0, 0, 1'b1, 32'd5100));
		send_sample(sample_of(1000, 1000, 20000, 0, 1'b1, 32'd10100));
		send_sample(sample_of(2100, 1995, 0, -20000, 1'b1, 32'd10200));
		send_sample(sample_of(2100, 1994, 0, -20000, 1'b1, 32'd10300));
		send_sample(sample_of(2866, 1229, 0, 0, 1'b0, 32'd10400));
		send_sample(sample_of(2867, 1228, 0, 0, 1'b0, 32'd10500));
		send_sample(sample_of(1638, 2457, 0, 0, 1'b1, 32'd10600));
		send_sample(sample_of(1639, 2456, 0, 0, 1'b1, 32'd10700));
		send_sample(sample_of(32'hAAA, 32'h555, 32'h5555, 32'hAAAA, 1'b1, 32'hAAAA_AAAA));
		send_sample(sample_of(32'h555, 32'hAAA, 32'hAAAA, 32'h5555, 1'b1, 32'h5555_5555));
		send_sample(sample_of(4095, 0, -32768, -32768, 1'b1, 32'hFFFF_FFFF));
		send_sample(sample_of(4095, 0, 32767, 32767, 1'b1, 32'h0000_0010));
		sim_ms = 32'h0000_0010;
	endtask

	task automatic test_open_thresholds();
		program_regs(16'd4095, 16'd0, 16'd0, 16'd4096, 16'd0, 16'd0, 16'd0, 16'd0);
		set_pace(0, 0);
		run_random(150);
	endtask

	task automatic test_closed_thresholds();
		program_regs(16'd0, 16'd4095, 16'd4096, 16'd0, 16'd32768, 16'd65535, 16'd65535,
			16'd65535);
		set_pace(64, 0);
		run_random(150);
	endtask

	// Upper data bits above a register's width are junk and must be dropped.
	task automatic test_random_thresholds();
		repeat (2) begin
			program_regs({4'($urandom), 12'($urandom)}, {4'($urandom), 12'($urandom)},
				{3'($urandom), 13'($urandom_range(4096))},
				{3'($urandom), 13'($urandom_range(4096))},
				16'($urandom_range(32768)), 16'($urandom_range(6000)),
				16'($urandom_range(6000)), 16'($urandom_range(6000)));
			if (stall_pct == 64) set_pace(26, 26);
			else set_pace(0, 64);
			run_random(150);
		end
	endtask

	task automatic test_input_backpressure();
		program_regs(RST_DROWSY_HIGH, RST_DROWSY_LOW, RST_ATTENTION_LOW, RST_ATTENTION_MID,
			RST_TILT_LIMIT, RST_BEEP_MS, RST_COOLDOWN_MS, RST_SEND_INTERVAL);
		set_pace(0, 0);
		hold_cycles = 200;
		run_random(60);
	endtask

	task automatic test_mixed_pacing();
		program_regs(16'd2000, 16'd1000, 16'd3000, 16'd3500, 16'd32767, 16'd65535, 16'd1,
			16'd1000);
		set_pace(26, 26);
		run_random(150);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_cases();
		test_open_thresholds();
		test_closed_thresholds();
		test_random_thresholds();
		test_input_backpressure();
		test_mixed_pacing();
		wait_idle();
		if (mismatch_count == 0 && pending_alerts.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
